// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, register indexes, character codes, reset values, the
// sequencer state type and the item structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// default screen store geometry
	localparam int TCW_MAX_COLUMNS = 128;
	localparam int TCW_MAX_ROWS    = 32;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR       = 8'd3;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET    = 6'd25;
	localparam logic [3:0] FG_RESET      = 4'd7;
	localparam logic [3:0] BG_RESET      = 4'd0;

	// character codes
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// cell layout: attribute in the high byte, character in the low byte
	localparam int CELL_W = 16;

	typedef enum logic [1:0] {
		CMD_PUT        = 2'd0,
		CMD_SET_CURSOR = 2'd1,
		CMD_CLEAR      = 2'd2,
		CMD_READ       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCROLL,
		S_FILL,
		S_CLEAR,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_code;
		logic [4:0] row_sel;
		logic [6:0] col_sel;
	} item_t;

	typedef struct packed {
		logic [11:0] cursor_address;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} result_t;

endpackage

`default_nettype wire

// File: design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: handshake channels of the text console writer
// Command channel, result channel and configuration write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] char_code;
	logic [4:0] row_sel;
	logic [6:0] col_sel;

	modport source (output valid, output cmd, output char_code, output row_sel,
		output col_sel, input ready);
	modport sink (input valid, input cmd, input char_code, input row_sel,
		input col_sel, output ready);
endinterface

interface tcw_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] cursor_address;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;

	modport source (output valid, output cursor_address, output cell_char,
		output cell_attr, input ready);
	modport sink (input valid, input cursor_address, input cell_char,
		input cell_attr, output ready);
endinterface

interface tcw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/text_console_writer_unit.sv
// Put, set cursor: result passes states S_EXEC and S_DONE to the output register; read also S_READ.
// Scroll (line end on the last row) adds a pass that moves the rows up and a space fill of the last row.
// Clear sweeps the whole store, all MAX_COLUMNS*MAX_ROWS cells.
// One item in flight; a new item can be taken when the sequencer is back in S_IDLE,
// while the previous result waits in the output register. Single port write, single read.
// Reset: clearing pass over all MAX_COLUMNS*MAX_ROWS cells, no items taken meanwhile.
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode screen buffer engine
// Configuration registers, output register and the cell store around the
// command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
	parameter int MAX_COLUMNS = tcw_pkg::TCW_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcw_pkg::TCW_MAX_ROWS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tcw_cmd_if.sink      cmd_ch,
	tcw_result_if.source result_ch,
	tcw_cfg_if.sink      cfg_ch
);

	import tcw_pkg::*;

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW   = $clog2(MAX_COLUMNS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);

	logic [7:0]        columns_q;
	logic [5:0]        rows_q;
	logic [3:0]        fg_q, bg_q;
	logic [CNW-1:0]    cols_eff;
	logic [RNW-1:0]    rows_eff;
	item_t             item;
	result_t           res, out_q;
	logic              out_valid_q;
	logic              res_valid, res_take, item_ready;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// configuration writes
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
			fg_q      <= FG_RESET;
			bg_q      <= BG_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_SCREEN_COLUMNS: columns_q <= cfg_ch.data;
				REG_SCREEN_ROWS:    rows_q    <= cfg_ch.data[5:0];
				REG_FG_COLOR:       fg_q      <= cfg_ch.data[3:0];
				REG_BG_COLOR:       bg_q      <= cfg_ch.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// geometry in use: zero counts as one, large values cap at the store size
	always_comb begin
		if (columns_q == '0) begin
			cols_eff = CNW'(1);
		end else if (int'(columns_q) > MAX_COLUMNS) begin
			cols_eff = CNW'(MAX_COLUMNS);
		end else begin
			cols_eff = CNW'(columns_q);
		end
		if (rows_q == '0) begin
			rows_eff = RNW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = RNW'(MAX_ROWS);
		end else begin
			rows_eff = RNW'(rows_q);
		end
	end

	// command item
	assign item.cmd       = cmd_t'(cmd_ch.cmd);
	assign item.char_code = cmd_ch.char_code;
	assign item.row_sel   = cmd_ch.row_sel;
	assign item.col_sel   = cmd_ch.col_sel;
	assign cmd_ch.ready   = item_ready;

	tcw_engine #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.CNW         (CNW),
		.RNW         (RNW),
		.AW          (AW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd_ch.valid),
		.item_ready (item_ready),
		.item       (item),
		.cols       (cols_eff),
		.rows       (rows_eff),
		.attr       ({bg_q, fg_q}),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	assign res_take = res_valid && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.cursor_address = out_q.cursor_address;
	assign result_ch.cell_char      = out_q.cell_char;
	assign result_ch.cell_attr      = out_q.cell_attr;

endmodule

`default_nettype wire

// File: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: design/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine: command sequencer of the text console writer
// Holds the cursor, drives the cell store through read-modify-write passes
// (put, read, scroll move and fill, clear) and hands one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine #(
	parameter int MAX_COLUMNS = tcw_pkg::TCW_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcw_pkg::TCW_MAX_ROWS,
	parameter int CNW         = $clog2(MAX_COLUMNS + 1),
	parameter int RNW         = $clog2(MAX_ROWS + 1),
	parameter int AW          = (MAX_COLUMNS * MAX_ROWS > 1) ?
		$clog2(MAX_COLUMNS * MAX_ROWS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// command items
	input  wire logic                    item_valid,
	output logic                         item_ready,
	input  wire tcw_pkg::item_t          item,
	// live geometry and attribute
	input  wire logic [CNW-1:0]          cols,
	input  wire logic [RNW-1:0]          rows,
	input  wire logic [7:0]              attr,
	// result hand-off
	output logic                         res_valid,
	input  wire logic                    res_take,
	output tcw_pkg::result_t             res,
	// cell store
	output logic                         ram_we,
	output logic [AW-1:0]                ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]   ram_wdata,
	output logic [AW-1:0]                ram_raddr,
	input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

	import tcw_pkg::*;

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SW    = $clog2(DEPTH + 1);
	localparam int LW    = RW + CNW;
	localparam int PW    = RNW + CNW;

	state_t         state_q, state_d;
	cmd_t           cmd_s1;
	logic [7:0]     char_s1;
	logic [RW-1:0]  rsel_s1, row_q, row_cl, rsel_cl;
	logic [CW-1:0]  csel_s1, col_q, col_cl, csel_cl;
	logic [CW:0]    col_inc;
	logic [SW-1:0]  tot_q, sweep_q;
	logic           pend_s1;
	logic [AW-1:0]  wa_s1;
	logic [7:0]     rd_char_q, rd_attr_q;
	logic [LW-1:0]  cur_lin, sel_lin;
	logic           is_newline, wrap, at_bottom, line_end, scroll_start;

	// row-major cell offset
	function automatic logic [LW-1:0] lin(input logic [RW-1:0] r,
		input logic [CW-1:0] c, input logic [CNW-1:0] n);
		return LW'(r) * LW'(n) + LW'(c);
	endfunction

	// clamp cursor and selections into the screen in use
	always_comb begin
		row_cl  = row_q;
		col_cl  = col_q;
		rsel_cl = RW'(item.row_sel);
		csel_cl = CW'(item.col_sel);
		if (int'(row_q) > int'(rows) - 1) begin
			row_cl = RW'(rows - RNW'(1));
		end
		if (int'(col_q) > int'(cols) - 1) begin
			col_cl = CW'(cols - CNW'(1));
		end
		if (int'(item.row_sel) > int'(rows) - 1) begin
			rsel_cl = RW'(rows - RNW'(1));
		end
		if (int'(item.col_sel) > int'(cols) - 1) begin
			csel_cl = CW'(cols - CNW'(1));
		end
	end

	// put decode
	assign cur_lin      = lin(row_q, col_q, cols);
	assign sel_lin      = lin(rsel_s1, csel_s1, cols);
	assign col_inc      = (CW+1)'(col_q) + (CW+1)'(1);
	assign is_newline   = (char_s1 == CHAR_NEWLINE);
	assign wrap         = (int'(col_inc) >= int'(cols));
	assign at_bottom    = (int'(row_q) >= int'(rows) - 1);
	assign line_end     = is_newline || wrap;
	assign scroll_start = line_end && at_bottom;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sweep_q == SW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_s1)
					CMD_PUT:        state_d = scroll_start ? S_SCROLL : S_DONE;
					CMD_SET_CURSOR: state_d = S_DONE;
					CMD_CLEAR:      state_d = S_CLEAR;
					CMD_READ:       state_d = S_READ;
				endcase
			end
			S_READ: state_d = S_DONE;
			S_SCROLL: begin
				if (sweep_q == tot_q && !pend_s1) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				if (sweep_q == tot_q - SW'(1)) begin
					state_d = S_DONE;
				end
			end
			S_CLEAR: begin
				if (sweep_q == SW'(DEPTH - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// store access and handshake outputs
	always_comb begin
		item_ready = (state_q == S_IDLE);
		res_valid  = (state_q == S_DONE);
		ram_we     = 1'b0;
		ram_waddr  = AW'(sweep_q);
		ram_wdata  = {attr, CHAR_NUL};
		ram_raddr  = AW'(sweep_q);
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_EXEC: begin
				if (cmd_s1 == CMD_PUT && !is_newline) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cur_lin);
					ram_wdata = {attr, char_s1};
				end
				ram_raddr = AW'(sel_lin);
			end
			S_SCROLL: begin
				ram_we    = pend_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = {attr, CHAR_SPACE};
			end
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE, S_READ, S_DONE: begin
			end
		endcase
	end

	// result fields
	always_comb begin
		res.cursor_address = 12'(cur_lin);
		res.cell_char      = rd_char_q;
		res.cell_attr      = rd_attr_q;
	end

	// control state: sequencer, cursor, sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_INIT, S_FILL, S_CLEAR: begin
					sweep_q <= sweep_q + SW'(1);
				end
				S_IDLE: begin
					row_q <= row_cl;
					col_q <= col_cl;
				end
				S_EXEC: begin
					unique case (cmd_s1)
						CMD_PUT: begin
							if (line_end) begin
								col_q   <= '0;
								sweep_q <= SW'(cols);
								if (!at_bottom) begin
									row_q <= row_q + RW'(1);
								end
							end else begin
								col_q <= CW'(col_inc);
							end
						end
						CMD_SET_CURSOR: begin
							row_q <= rsel_s1;
							col_q <= csel_s1;
						end
						CMD_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							sweep_q <= '0;
						end
						CMD_READ: begin
						end
					endcase
				end
				S_SCROLL: begin
					// move pass: read one row down, write it back one row up from the registered read data
					if (sweep_q != tot_q) begin
						sweep_q <= sweep_q + SW'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							sweep_q <= tot_q - SW'(cols);
						end
					end
				end
				S_READ, S_DONE: begin
				end
			endcase
		end
	end

	// item payload and read data
	always_ff @(posedge clk) begin
		wa_s1 <= AW'(sweep_q - SW'(cols));
		if (state_q == S_IDLE && item_valid) begin
			cmd_s1  <= item.cmd;
			char_s1 <= item.char_code;
			rsel_s1 <= rsel_cl;
			csel_s1 <= csel_cl;
			tot_q   <= SW'(PW'(rows) * PW'(cols));
		end
		if (state_q == S_EXEC) begin
			rd_char_q <= '0;
			rd_attr_q <= '0;
		end
		if (state_q == S_READ) begin
			rd_char_q <= ram_rdata[7:0];
			// cursor mark: swap attribute nibbles
			if (rsel_s1 == row_q && csel_s1 == col_q) begin
				rd_attr_q <= {ram_rdata[11:8], ram_rdata[15:12]};
			end else begin
				rd_attr_q <= ram_rdata[15:8];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Sequencing of command and result channels seen from the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] out_cursor_address,
	input wire logic [7:0]  out_cell_char,
	input wire logic [7:0]  out_cell_attr
);

	// one item at a time: no item taken right after another
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("command item taken in the cycle after an accept");

	// store clearing pass holds off items after reset
	a_init_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("command channel ready during the reset clearing pass");

	// a fresh result follows work with the command channel closed in the previous cycle
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the command channel was open");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_cursor_address)
			&& $stable(out_cell_char) && $stable(out_cell_attr)))
		else $error("stalled result changed or dropped");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (cmd_ch.valid),
	.in_ready           (cmd_ch.ready),
	.out_valid          (result_ch.valid),
	.out_ready          (result_ch.ready),
	.out_cursor_address (result_ch.cursor_address),
	.out_cell_char      (result_ch.cell_char),
	.out_cell_attr      (result_ch.cell_attr)
);

`default_nettype wire
